>>> src/tgs_pkg.sv
// ----------------------------------------------------------------------------
// tgs_pkg
// Shared widths, codes, hand-off queue entry and the sRGB lookup tables of
// the texel greyscale sampler.
// ----------------------------------------------------------------------------
package tgs_pkg;

    localparam int MAX_PIXELS     = 65536;
    localparam int MAX_SIDE       = 256;
    localparam int ADDR_W         = $clog2(MAX_PIXELS);
    localparam int SIDE_W         = $clog2(MAX_SIDE);
    localparam int SIZE_W         = 9;
    localparam int COORD_W        = 17;
    localparam int COORD_FRAC     = 15;
    localparam int CLAMP_W        = COORD_FRAC + 1;
    localparam int PIXEL_IDX_W    = 16;
    localparam int CHAN_W         = 8;
    localparam int PIXEL_W        = 3 * CHAN_W;
    localparam int LIN_W          = 17;
    localparam int WEIGHT_W       = 16;
    localparam int GREY_W         = 8;
    localparam int CFG_INDEX_W    = 2;
    localparam int QUEUE_DEPTH    = 4;
    localparam int QCNT_W         = $clog2(QUEUE_DEPTH + 1);
    localparam int TAB_SIZE       = 1 << CHAN_W;
    // accept edge to the edge that takes the result
    localparam int RESULT_LATENCY = 15;

    localparam logic [CLAMP_W-1:0]  COORD_ONE    = CLAMP_W'(1 << COORD_FRAC);
    localparam logic [WEIGHT_W-1:0] WEIGHT_RED   = WEIGHT_W'(13933);
    localparam logic [WEIGHT_W-1:0] WEIGHT_GREEN = WEIGHT_W'(46871);
    localparam logic [WEIGHT_W-1:0] WEIGHT_BLUE  = WEIGHT_W'(4732);

    typedef enum logic {
        CMD_SAMPLE = 1'b0,
        CMD_WRITE  = 1'b1
    } t_cmd;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_IMAGE_WIDTH  = 2'd0,
        CFG_IMAGE_HEIGHT = 2'd1
    } t_cfg_index;

    typedef struct packed {
        logic                is_write;
        logic [ADDR_W-1:0]   addr;
        logic [PIXEL_W-1:0]  pixel;
    } t_queue_entry;

    typedef logic [TAB_SIZE-1:0][LIN_W-1:0] t_lin_tab;

    // Transfer-function constants for a code over 255 and a half step over 510
    localparam logic [63:0] ONE_Q30      = 64'd1 << 30;
    localparam logic [63:0] SEG_LIM_255  = 64'd1031475;
    localparam logic [63:0] SEG_LIM_510  = 64'd2062950;
    localparam logic [63:0] LIN_BIAS_255 = 64'd329460;
    localparam logic [63:0] LIN_BIAS_510 = 64'd658920;
    localparam logic [63:0] LIN_DIV_255  = 64'd658920;
    localparam logic [63:0] LIN_DIV_510  = 64'd1317840;
    localparam logic [63:0] OFFSET_255   = 64'd14025;
    localparam logic [63:0] OFFSET_510   = 64'd28050;
    localparam logic [63:0] POW_DIV_255  = 64'd269025;
    localparam logic [63:0] POW_DIV_510  = 64'd538050;

    function automatic logic [63:0] fifth_pow_q30(input logic [63:0] r);
        logic [63:0] r2;
        logic [63:0] r4;
        r2 = (r * r) >> 30;
        r4 = (r2 * r2) >> 30;
        return (r4 * r) >> 30;
    endfunction

    // sRGB to linear Q1.16; half selects a denominator of 510 instead of 255
    function automatic logic [LIN_W-1:0] srgb_lin(input logic [63:0] num, input logic half);
        logic [63:0] a;
        logic [63:0] a2;
        logic [63:0] r;
        logic [63:0] cand;
        logic [63:0] p;
        logic [63:0] q;
        int          b;
        if (!half) begin
            if (num * 64'd100000 < SEG_LIM_255) begin
                return LIN_W'((num * 64'd13107200 + LIN_BIAS_255) / LIN_DIV_255);
            end
            a = ((num * 64'd1000 + OFFSET_255) << 30) / POW_DIV_255;
        end else begin
            if (num * 64'd100000 < SEG_LIM_510) begin
                return LIN_W'((num * 64'd13107200 + LIN_BIAS_510) / LIN_DIV_510);
            end
            a = ((num * 64'd1000 + OFFSET_510) << 30) / POW_DIV_510;
        end
        if (a > ONE_Q30) begin
            a = ONE_Q30;
        end
        a2 = (a * a) >> 30;
        // fifth root of a squared, one bit a step
        r = 64'd0;
        for (b = 30; b >= 0; b--) begin
            cand = r | (64'd1 << b);
            if (cand <= ONE_Q30) begin
                if (fifth_pow_q30(cand) <= a2) begin
                    r = cand;
                end
            end
        end
        p = (a2 * r) >> 30;
        q = (p + 64'd8192) >> 14;
        return LIN_W'(q);
    endfunction

    function automatic t_lin_tab build_lin_tab();
        t_lin_tab tab;
        for (int c = 0; c < TAB_SIZE; c++) begin
            tab[c] = srgb_lin(64'(c), 1'b0);
        end
        return tab;
    endfunction

    // entry n holds the linear level at which the code n begins; entry 0 is unused
    function automatic t_lin_tab build_thr_tab();
        t_lin_tab tab;
        tab[0] = '0;
        for (int n = 1; n < TAB_SIZE; n++) begin
            tab[n] = srgb_lin(64'(2 * n - 1), 1'b1);
        end
        return tab;
    endfunction

    localparam t_lin_tab LIN_TAB = build_lin_tab();
    localparam t_lin_tab THR_TAB = build_thr_tab();

endpackage

>>> src/tgs_ram.sv
// ----------------------------------------------------------------------------
// tgs_ram
// Single-port RAM with registered read, read-before-write.
// ----------------------------------------------------------------------------
module tgs_ram #(
    parameter int WIDTH  = tgs_pkg::PIXEL_W,
    parameter int DEPTH  = tgs_pkg::MAX_PIXELS,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_addr,
    input  logic [WIDTH-1:0]  i_wdata,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> src/tgs_front.sv
// ----------------------------------------------------------------------------
// tgs_front
// Front end: holds the image size, classifies accepted items, clamps and
// scales coordinates into a texel address, and pushes store operations.
// ----------------------------------------------------------------------------
module tgs_front (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_accept,
    input  logic                                 i_cmd,
    input  logic signed [tgs_pkg::COORD_W-1:0]   i_tex_u,
    input  logic signed [tgs_pkg::COORD_W-1:0]   i_tex_v,
    input  logic [tgs_pkg::PIXEL_IDX_W-1:0]      i_pixel_index,
    input  logic [tgs_pkg::CHAN_W-1:0]           i_red,
    input  logic [tgs_pkg::CHAN_W-1:0]           i_green,
    input  logic [tgs_pkg::CHAN_W-1:0]           i_blue,
    input  logic                                 i_cfg_we,
    input  logic [tgs_pkg::CFG_INDEX_W-1:0]      i_cfg_index,
    input  logic [tgs_pkg::SIZE_W-1:0]           i_cfg_data,
    output logic                                 o_push,
    output tgs_pkg::t_queue_entry                o_entry,
    output logic [1:0]                           o_inflight
);

    localparam int PROD_W = tgs_pkg::CLAMP_W + tgs_pkg::SIZE_W;
    localparam int IDX_W  = PROD_W - tgs_pkg::COORD_FRAC;
    localparam int FULL_W = tgs_pkg::SIDE_W + tgs_pkg::SIZE_W + 1;

    function automatic logic [tgs_pkg::CLAMP_W-1:0] clamp_coord(
        input logic signed [tgs_pkg::COORD_W-1:0] c
    );
        if (c[tgs_pkg::COORD_W-1]) begin
            return '0;
        end
        if (c[tgs_pkg::CLAMP_W-1:0] > tgs_pkg::COORD_ONE) begin
            return tgs_pkg::COORD_ONE;
        end
        return c[tgs_pkg::CLAMP_W-1:0];
    endfunction

    function automatic logic [tgs_pkg::SIZE_W-1:0] clamp_size(
        input logic [tgs_pkg::SIZE_W-1:0] s
    );
        if (s == '0) begin
            return tgs_pkg::SIZE_W'(1);
        end
        if (s > tgs_pkg::SIZE_W'(tgs_pkg::MAX_SIDE)) begin
            return tgs_pkg::SIZE_W'(tgs_pkg::MAX_SIDE);
        end
        return s;
    endfunction

    // scale, truncate, pull the far edge back to size-1
    function automatic logic [tgs_pkg::SIDE_W-1:0] axis_index(
        input logic [tgs_pkg::CLAMP_W-1:0] c,
        input logic [tgs_pkg::SIZE_W-1:0]  size
    );
        logic [PROD_W-1:0]         prod;
        logic [IDX_W-1:0]          idx;
        logic [tgs_pkg::SIZE_W-1:0] last;
        prod = PROD_W'(c) * PROD_W'(size);
        idx  = prod[PROD_W-1:tgs_pkg::COORD_FRAC];
        last = size - tgs_pkg::SIZE_W'(1);
        if (idx >= IDX_W'(size)) begin
            return last[tgs_pkg::SIDE_W-1:0];
        end
        return idx[tgs_pkg::SIDE_W-1:0];
    endfunction

    logic [tgs_pkg::SIZE_W-1:0]      r_width;
    logic [tgs_pkg::SIZE_W-1:0]      r_height;

    logic                            r_f1_valid;
    logic                            r_f1_write;
    logic [tgs_pkg::CLAMP_W-1:0]     r_f1_u;
    logic [tgs_pkg::CLAMP_W-1:0]     r_f1_v;
    logic [tgs_pkg::PIXEL_IDX_W-1:0] r_f1_index;
    logic [tgs_pkg::PIXEL_W-1:0]     r_f1_pixel;

    logic                            r_f2_valid;
    logic                            r_f2_write;
    logic [tgs_pkg::SIDE_W-1:0]      r_f2_x;
    logic [tgs_pkg::SIDE_W-1:0]      r_f2_y;
    logic [tgs_pkg::PIXEL_IDX_W-1:0] r_f2_index;
    logic [tgs_pkg::PIXEL_W-1:0]     r_f2_pixel;

    logic [tgs_pkg::SIDE_W-1:0]      n_f2_x;
    logic [tgs_pkg::SIDE_W-1:0]      n_f2_y;
    logic [FULL_W-1:0]               n_addr_full;

    // configuration registers, stored already clamped to 1..MAX_SIDE
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= tgs_pkg::SIZE_W'(tgs_pkg::MAX_SIDE);
            r_height <= tgs_pkg::SIZE_W'(tgs_pkg::MAX_SIDE);
        end else if (i_cfg_we) begin
            case (tgs_pkg::t_cfg_index'(i_cfg_index))
                tgs_pkg::CFG_IMAGE_WIDTH:  r_width  <= clamp_size(i_cfg_data);
                tgs_pkg::CFG_IMAGE_HEIGHT: r_height <= clamp_size(i_cfg_data);
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f1_valid <= 1'b0;
            r_f2_valid <= 1'b0;
        end else begin
            r_f1_valid <= i_accept;
            r_f2_valid <= r_f1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_f1_write <= (i_cmd == tgs_pkg::CMD_WRITE);
        r_f1_u     <= clamp_coord(i_tex_u);
        r_f1_v     <= clamp_coord(i_tex_v);
        r_f1_index <= i_pixel_index;
        r_f1_pixel <= {i_red, i_green, i_blue};

        r_f2_write <= r_f1_write;
        r_f2_x     <= n_f2_x;
        r_f2_y     <= n_f2_y;
        r_f2_index <= r_f1_index;
        r_f2_pixel <= r_f1_pixel;
    end

    always_comb begin
        n_f2_x = axis_index(r_f1_u, r_width);
        n_f2_y = axis_index(r_f1_v, r_height);
    end

    // row-major address, wrapped to the store depth
    assign n_addr_full = FULL_W'(r_f2_y) * FULL_W'(r_width) + FULL_W'(r_f2_x);

    always_comb begin
        o_entry.is_write = r_f2_write;
        o_entry.pixel    = r_f2_pixel;
        if (r_f2_write) begin
            o_entry.addr = tgs_pkg::ADDR_W'(r_f2_index);
        end else begin
            o_entry.addr = n_addr_full[tgs_pkg::ADDR_W-1:0];
        end
    end

    assign o_push     = r_f2_valid;
    assign o_inflight = {1'b0, r_f1_valid} + {1'b0, r_f2_valid};

    a_index_in_image: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_f2_valid && !r_f2_write) |->
            (tgs_pkg::SIZE_W'(r_f2_x) < r_width) && (tgs_pkg::SIZE_W'(r_f2_y) < r_height))
        else $error("texel index outside image");

endmodule

>>> src/tgs_queue.sv
// ----------------------------------------------------------------------------
// tgs_queue
// Short FIFO between front and back end; the back end drains one entry
// per cycle whenever the queue holds one.
// ----------------------------------------------------------------------------
module tgs_queue (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_push,
    input  tgs_pkg::t_queue_entry         i_entry,
    output logic                          o_valid,
    output tgs_pkg::t_queue_entry         o_entry,
    output logic [tgs_pkg::QCNT_W-1:0]    o_count
);

    localparam int PTR_W = (tgs_pkg::QUEUE_DEPTH > 1) ? $clog2(tgs_pkg::QUEUE_DEPTH) : 1;

    tgs_pkg::t_queue_entry          r_mem [tgs_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0]               r_wr_ptr;
    logic [PTR_W-1:0]               r_rd_ptr;
    logic [tgs_pkg::QCNT_W-1:0]     r_count;
    logic                           pop;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        if (p == PTR_W'(tgs_pkg::QUEUE_DEPTH - 1)) begin
            return '0;
        end
        return p + PTR_W'(1);
    endfunction

    assign pop = (r_count != '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ptr_inc(r_wr_ptr);
            end
            if (pop) begin
                r_rd_ptr <= ptr_inc(r_rd_ptr);
            end
            case ({i_push, pop})
                2'b10:   r_count <= r_count + tgs_pkg::QCNT_W'(1);
                2'b01:   r_count <= r_count - tgs_pkg::QCNT_W'(1);
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    assign o_valid = pop;
    assign o_entry = r_mem[r_rd_ptr];
    assign o_count = r_count;

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !pop) |-> (r_count < tgs_pkg::QCNT_W'(tgs_pkg::QUEUE_DEPTH)))
        else $error("hand-off queue overflow");

endmodule

>>> src/tgs_back.sv
// ----------------------------------------------------------------------------
// tgs_back
// Back end: pixel store access, channel linearization, luminance weighting
// and a pipelined binary search back to an sRGB code.
// ----------------------------------------------------------------------------
module tgs_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  tgs_pkg::t_queue_entry         i_entry,
    output logic                          o_grey_valid,
    output logic [tgs_pkg::GREY_W-1:0]    o_grey
);

    localparam int STEPS  = tgs_pkg::GREY_W;
    localparam int PROD_W = 32;
    localparam int SUM_W  = PROD_W + 1;

    logic [tgs_pkg::PIXEL_W-1:0] rd_pixel;

    logic                        r_b1_valid;
    logic                        r_b2_valid;
    logic                        r_b3_valid;
    logic [tgs_pkg::LIN_W-1:0]   r_lin_red;
    logic [tgs_pkg::LIN_W-1:0]   r_lin_green;
    logic [tgs_pkg::LIN_W-1:0]   r_lin_blue;
    logic [PROD_W-1:0]           r_prod_red;
    logic [PROD_W-1:0]           r_prod_green;
    logic [PROD_W-1:0]           r_prod_blue;
    logic [SUM_W-1:0]            n_sum;

    logic [STEPS:0]              r_srch_v;
    logic [tgs_pkg::GREY_W-1:0]  r_srch_k [STEPS+1];
    logic [tgs_pkg::LIN_W-1:0]   r_srch_y [STEPS+1];
    logic [tgs_pkg::GREY_W-1:0]  n_srch_k [STEPS+1];
    logic [tgs_pkg::GREY_W-1:0]  n_cand   [STEPS+1];

    tgs_ram #(
        .WIDTH (tgs_pkg::PIXEL_W),
        .DEPTH (tgs_pkg::MAX_PIXELS)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (i_valid && i_entry.is_write),
        .i_addr  (i_entry.addr),
        .i_wdata (i_entry.pixel),
        .o_rdata (rd_pixel)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b1_valid <= 1'b0;
            r_b2_valid <= 1'b0;
            r_b3_valid <= 1'b0;
            r_srch_v   <= '0;
        end else begin
            r_b1_valid <= i_valid && !i_entry.is_write;
            r_b2_valid <= r_b1_valid;
            r_b3_valid <= r_b2_valid;
            r_srch_v   <= {r_srch_v[STEPS-1:0], r_b3_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        r_lin_red    <= tgs_pkg::LIN_TAB[rd_pixel[23:16]];
        r_lin_green  <= tgs_pkg::LIN_TAB[rd_pixel[15:8]];
        r_lin_blue   <= tgs_pkg::LIN_TAB[rd_pixel[7:0]];

        r_prod_red   <= PROD_W'(r_lin_red   * tgs_pkg::WEIGHT_RED);
        r_prod_green <= PROD_W'(r_lin_green * tgs_pkg::WEIGHT_GREEN);
        r_prod_blue  <= PROD_W'(r_lin_blue  * tgs_pkg::WEIGHT_BLUE);

        r_srch_y[0]  <= n_sum[SUM_W-1:16];
        r_srch_k[0]  <= '0;
        for (int s = 1; s <= STEPS; s++) begin
            r_srch_y[s] <= r_srch_y[s-1];
            r_srch_k[s] <= n_srch_k[s];
        end
    end

    // round the weighted sum to Q1.16
    assign n_sum = SUM_W'(r_prod_red) + SUM_W'(r_prod_green) + SUM_W'(r_prod_blue)
                 + SUM_W'(32768);

    // thresholds rise with the code: settle one code bit per stage, MSB first
    always_comb begin
        n_srch_k[0] = '0;
        n_cand[0]   = '0;
        for (int s = 1; s <= STEPS; s++) begin
            n_cand[s] = r_srch_k[s-1] | (tgs_pkg::GREY_W'(1) << (STEPS - s));
            if (r_srch_y[s-1] >= tgs_pkg::THR_TAB[n_cand[s]]) begin
                n_srch_k[s] = n_cand[s];
            end else begin
                n_srch_k[s] = r_srch_k[s-1];
            end
        end
    end

    assign o_grey_valid = r_srch_v[STEPS];
    assign o_grey       = r_srch_k[STEPS];

endmodule

>>> src/texel_greyscale_sampler_top.sv
// ----------------------------------------------------------------------------
// texel_greyscale_sampler_top
// RGB pixel store sampled at clamped texture coordinates; returns the sRGB
// luminance of the nearest texel.
// ----------------------------------------------------------------------------
//  channel   | handshake                     | payload
//  ----------+-------------------------------+-------------------------------
//  command   | start / busy                  | i_cmd i_tex_u i_tex_v
//            |                               | i_pixel_index i_red i_green
//            |                               | i_blue
//  result    | o_grey_valid (one-cycle pulse)| o_grey
//  config    | i_cfg_valid / o_cfg_ready     | i_cfg_index i_cfg_data
//
//  One command per clock while busy is low. Each sample yields a result on
//  o_grey; a write yields no result. The rate is set by the single
//  pixel-store port, used once per command in the back end.
//  Reset (synchronous, active low) clears the pipeline and queue and sets
//  both image sizes to 256; the pixel store is not cleared and reads
//  undefined until written. The receiver cannot stall: the back end drains
//  the hand-off queue every cycle, so busy only guards queue space.
// ----------------------------------------------------------------------------
module texel_greyscale_sampler_top (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  logic                                 i_cmd,
    input  logic signed [tgs_pkg::COORD_W-1:0]   i_tex_u,
    input  logic signed [tgs_pkg::COORD_W-1:0]   i_tex_v,
    input  logic [tgs_pkg::PIXEL_IDX_W-1:0]      i_pixel_index,
    input  logic [tgs_pkg::CHAN_W-1:0]           i_red,
    input  logic [tgs_pkg::CHAN_W-1:0]           i_green,
    input  logic [tgs_pkg::CHAN_W-1:0]           i_blue,
    output logic                                 o_grey_valid,
    output logic [tgs_pkg::GREY_W-1:0]           o_grey,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [tgs_pkg::CFG_INDEX_W-1:0]      i_cfg_index,
    input  logic [tgs_pkg::SIZE_W-1:0]           i_cfg_data
);

    localparam int OCC_W   = tgs_pkg::QCNT_W + 1;
    localparam int LATENCY = tgs_pkg::RESULT_LATENCY;

    logic                          accept;
    logic                          q_push;
    tgs_pkg::t_queue_entry         q_in;
    logic                          q_valid;
    tgs_pkg::t_queue_entry         q_out;
    logic [tgs_pkg::QCNT_W-1:0]    q_count;
    logic [1:0]                    inflight;
    logic [OCC_W-1:0]              occupancy;

    assign o_cfg_ready = 1'b1;
    assign accept      = start && !busy;

    // count entries already in the front pipeline against queue space
    assign occupancy = OCC_W'(q_count) + OCC_W'(inflight);
    assign busy      = (occupancy >= OCC_W'(tgs_pkg::QUEUE_DEPTH));

    tgs_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (accept),
        .i_cmd         (i_cmd),
        .i_tex_u       (i_tex_u),
        .i_tex_v       (i_tex_v),
        .i_pixel_index (i_pixel_index),
        .i_red         (i_red),
        .i_green       (i_green),
        .i_blue        (i_blue),
        .i_cfg_we      (i_cfg_valid && o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .o_push        (q_push),
        .o_entry       (q_in),
        .o_inflight    (inflight)
    );

    tgs_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_entry (q_in),
        .o_valid (q_valid),
        .o_entry (q_out),
        .o_count (q_count)
    );

    tgs_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (q_valid),
        .i_entry      (q_out),
        .o_grey_valid (o_grey_valid),
        .o_grey       (o_grey)
    );

    a_sample_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_cmd == tgs_pkg::CMD_SAMPLE) |-> ##LATENCY o_grey_valid)
        else $error("sample transfer without result");

    a_write_gives_none: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_cmd == tgs_pkg::CMD_WRITE) |-> ##LATENCY !o_grey_valid)
        else $error("write transfer produced a result");

    a_idle_gives_none: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !accept |-> ##LATENCY !o_grey_valid)
        else $error("result without a sample transfer");

endmodule
